// ===== sv/hsl_to_rgb_converter_core_assert.svh =====
// Assertion helpers for the HSL to RGB converter.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while the active-low reset is asserted.
`ifndef HSL_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication
`define H2R_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hsl2rgb: same-cycle check failed");

// Next-cycle implication
`define H2R_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hsl2rgb: next-cycle check failed");

`endif

// ===== sv/hsl2rgb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hsl2rgb_pkg;

	// Field types
	typedef logic [14:0] hue_t;     // degrees, Q9.6
	typedef logic [16:0] q16_t;     // Q1.16, 65536 is 1.0
	typedef logic [11:0] fac_t;     // ramp factor, 0..3840
	typedef logic signed [20:0] tmp_t; // temporaries and their difference

	// Hue positions in units of 1/64 degree
	localparam hue_t FULL_TURN       = 15'd23040;
	localparam hue_t THIRD_TURN      = 15'd7680;
	localparam hue_t SIXTH_TURN      = 15'd3840;
	localparam hue_t HALF_TURN       = 15'd11520;
	localparam hue_t TWO_THIRDS_TURN = 15'd15360;

	localparam q16_t ONE_Q16  = 17'd65536;
	localparam q16_t HALF_Q16 = 17'd32768;

	// floor(2^28 / 15); exact since 15 divides 2^28 - 1
	localparam logic [24:0] RECIP15 = 25'd17895697;
	localparam int RECIP_SHIFT = 28;

	// Channel lanes
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;
	localparam int NUM_CH   = 3;

	// Ramp factor for a channel position: value = lo + (hi - lo) * f / 3840.
	// Flat top uses f = 3840 (gives hi exactly), flat bottom f = 0.
	function automatic fac_t seg_factor(input hue_t t);
		hue_t fall;
		fall = TWO_THIRDS_TURN - t;
		if (t < SIXTH_TURN) begin
			seg_factor = t[11:0];
		end else if (t < HALF_TURN) begin
			seg_factor = SIXTH_TURN[11:0];
		end else if (t < TWO_THIRDS_TURN) begin
			seg_factor = fall[11:0];
		end else begin
			seg_factor = '0;
		end
	endfunction

endpackage

`default_nettype wire

// ===== sv/hsl2rgb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// HSL pixel request channel
interface hsl2rgb_hsl_if;
	logic               valid;
	logic               ready;
	hsl2rgb_pkg::hue_t  hue_deg;
	hsl2rgb_pkg::q16_t  sat;
	hsl2rgb_pkg::q16_t  light;

	modport source (output valid, hue_deg, sat, light, input ready);
	modport sink   (input valid, hue_deg, sat, light, output ready);
endinterface

// RGB pixel result channel
interface hsl2rgb_rgb_if;
	logic               valid;
	logic               ready;
	hsl2rgb_pkg::q16_t  red_out;
	hsl2rgb_pkg::q16_t  green_out;
	hsl2rgb_pkg::q16_t  blue_out;

	modport source (output valid, red_out, green_out, blue_out, input ready);
	modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

`default_nettype wire

// ===== sv/hsl_to_rgb_converter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "hsl_to_rgb_converter_core_assert.svh"

// HSL to RGB pixel converter. Takes one pixel request per clock unless stalled
// and returns one RGB result per request, in order. An accepted request moves
// through stage registers s1 to s7; the result channel is driven from s7.
// Throughput is one pixel per clock while the result channel is not stalled.
// The seven-stage pipeline is saturation product, temporaries, ramp product,
// magnitude, divide-by-3840 as a reciprocal multiply, its one-step correction,
// and the final add with clamp to 0..65536. Every stage has its own valid bit and
// loads when it is empty or its successor moves, so back-pressure on the
// result channel fills bubbles first and only then deasserts hsl.ready.
// Hue of 360 degrees or more is taken modulo a full turn once.
module hsl_to_rgb_converter_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	hsl2rgb_hsl_if.sink     hsl,
	hsl2rgb_rgb_if.source   rgb
);

	// Stage valid bits and load enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic load1, load2, load3, load4, load5, load6, load7;

	assign load7 = !vld_s7 || rgb.ready;
	assign load6 = !vld_s6 || load7;
	assign load5 = !vld_s5 || load6;
	assign load4 = !vld_s4 || load5;
	assign load3 = !vld_s3 || load4;
	assign load2 = !vld_s2 || load3;
	assign load1 = !vld_s1 || load2;

	assign hsl.ready = load1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (load1) vld_s1 <= hsl.valid;
			if (load2) vld_s2 <= vld_s1;
			if (load3) vld_s3 <= vld_s2;
			if (load4) vld_s4 <= vld_s3;
			if (load5) vld_s5 <= vld_s4;
			if (load6) vld_s6 <= vld_s5;
			if (load7) vld_s7 <= vld_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: hue reduction, channel positions, ramp factors, S*L product
	// ------------------------------------------------------------------
	hsl2rgb_pkg::hue_t hue_r;
	hsl2rgb_pkg::hue_t pos_c [hsl2rgb_pkg::NUM_CH];
	logic [15:0]       red_sum;
	logic              low_l;
	logic [17:0]       mul_b;

	always_comb begin
		hue_r = (hsl.hue_deg >= hsl2rgb_pkg::FULL_TURN) ?
			hsl.hue_deg - hsl2rgb_pkg::FULL_TURN : hsl.hue_deg;

		red_sum = {1'b0, hue_r} + {1'b0, hsl2rgb_pkg::THIRD_TURN};
		if (red_sum >= {1'b0, hsl2rgb_pkg::FULL_TURN}) begin
			red_sum = red_sum - {1'b0, hsl2rgb_pkg::FULL_TURN};
		end
		pos_c[hsl2rgb_pkg::CH_RED]   = red_sum[14:0];
		pos_c[hsl2rgb_pkg::CH_GREEN] = hue_r;
		pos_c[hsl2rgb_pkg::CH_BLUE]  = (hue_r < hsl2rgb_pkg::THIRD_TURN) ?
			hue_r + hsl2rgb_pkg::TWO_THIRDS_TURN : hue_r - hsl2rgb_pkg::THIRD_TURN;

		// L*(1+S) below one half, else L*S
		low_l = hsl.light < hsl2rgb_pkg::HALF_Q16;
		mul_b = low_l ? {1'b0, hsl.sat} + {1'b0, hsl2rgb_pkg::ONE_Q16} : {1'b0, hsl.sat};
	end

	logic [34:0]        prod_s1;
	logic               low_s1;
	hsl2rgb_pkg::q16_t  light_s1, sat_s1;
	hsl2rgb_pkg::fac_t  fac_s1 [hsl2rgb_pkg::NUM_CH];

	always_ff @(posedge clk) begin
		if (load1) begin
			prod_s1  <= 35'(hsl.light) * 35'(mul_b);
			low_s1   <= low_l;
			light_s1 <= hsl.light;
			sat_s1   <= hsl.sat;
			for (int c = 0; c < hsl2rgb_pkg::NUM_CH; c++) begin
				fac_s1[c] <= hsl2rgb_pkg::seg_factor(pos_c[c]);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: upper/lower temporaries, difference
	// ------------------------------------------------------------------
	hsl2rgb_pkg::tmp_t hi_c, lo_c, shr_c, light_x, sat_x;

	always_comb begin
		shr_c   = signed'(21'(prod_s1[34:16]));
		light_x = signed'(21'(light_s1));
		sat_x   = signed'(21'(sat_s1));
		hi_c    = low_s1 ? shr_c : light_x + sat_x - shr_c;
		lo_c    = (light_x <<< 1) - hi_c;
	end

	hsl2rgb_pkg::tmp_t lo_s2, dif_s2;
	hsl2rgb_pkg::fac_t fac_s2 [hsl2rgb_pkg::NUM_CH];

	always_ff @(posedge clk) begin
		if (load2) begin
			lo_s2  <= lo_c;
			dif_s2 <= hi_c - lo_c;
			fac_s2 <= fac_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: ramp products (T2-T1)*f per channel
	// ------------------------------------------------------------------
	hsl2rgb_pkg::tmp_t  lo_s3;
	logic signed [33:0] ramp_s3 [hsl2rgb_pkg::NUM_CH];

	always_ff @(posedge clk) begin
		if (load3) begin
			lo_s3 <= lo_s2;
			for (int c = 0; c < hsl2rgb_pkg::NUM_CH; c++) begin
				ramp_s3[c] <= 34'(dif_s2) * 34'(signed'({1'b0, fac_s2[c]}));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: magnitude, pre-divide by 256 (3840 = 256 * 15)
	// ------------------------------------------------------------------
	logic [33:0] mag_c [hsl2rgb_pkg::NUM_CH];

	always_comb begin
		for (int c = 0; c < hsl2rgb_pkg::NUM_CH; c++) begin
			mag_c[c] = ramp_s3[c][33] ? 34'(-ramp_s3[c]) : 34'(ramp_s3[c]);
		end
	end

	hsl2rgb_pkg::tmp_t lo_s4;
	logic [24:0]       num_s4 [hsl2rgb_pkg::NUM_CH];
	logic              neg_s4 [hsl2rgb_pkg::NUM_CH];

	always_ff @(posedge clk) begin
		if (load4) begin
			lo_s4 <= lo_s3;
			for (int c = 0; c < hsl2rgb_pkg::NUM_CH; c++) begin
				num_s4[c] <= mag_c[c][32:8];
				neg_s4[c] <= ramp_s3[c][33];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: quotient estimate by 15, may be one low
	// ------------------------------------------------------------------
	logic [49:0] recip_c [hsl2rgb_pkg::NUM_CH];

	always_comb begin
		for (int c = 0; c < hsl2rgb_pkg::NUM_CH; c++) begin
			recip_c[c] = 50'(num_s4[c]) * 50'(hsl2rgb_pkg::RECIP15);
		end
	end

	hsl2rgb_pkg::tmp_t lo_s5;
	logic [24:0]       num_s5 [hsl2rgb_pkg::NUM_CH];
	logic [21:0]       qest_s5 [hsl2rgb_pkg::NUM_CH];
	logic              neg_s5 [hsl2rgb_pkg::NUM_CH];

	always_ff @(posedge clk) begin
		if (load5) begin
			lo_s5  <= lo_s4;
			num_s5 <= num_s4;
			neg_s5 <= neg_s4;
			for (int c = 0; c < hsl2rgb_pkg::NUM_CH; c++) begin
				qest_s5[c] <= recip_c[c][hsl2rgb_pkg::RECIP_SHIFT +: 22];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: remainder check and correction
	// ------------------------------------------------------------------
	logic [24:0] rem_c [hsl2rgb_pkg::NUM_CH];

	always_comb begin
		for (int c = 0; c < hsl2rgb_pkg::NUM_CH; c++) begin
			rem_c[c] = num_s5[c] - (25'({qest_s5[c], 4'b0000}) - 25'(qest_s5[c]));
		end
	end

	hsl2rgb_pkg::tmp_t lo_s6;
	logic [21:0]       quo_s6 [hsl2rgb_pkg::NUM_CH];
	logic              neg_s6 [hsl2rgb_pkg::NUM_CH];

	always_ff @(posedge clk) begin
		if (load6) begin
			lo_s6  <= lo_s5;
			neg_s6 <= neg_s5;
			for (int c = 0; c < hsl2rgb_pkg::NUM_CH; c++) begin
				quo_s6[c] <= (rem_c[c] >= 25'd15) ? qest_s5[c] + 22'd1 : qest_s5[c];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: T1 + signed quotient, clamp to 0..1.0
	// ------------------------------------------------------------------
	logic signed [23:0]  sum_c [hsl2rgb_pkg::NUM_CH];
	logic signed [22:0]  sq_c  [hsl2rgb_pkg::NUM_CH];
	hsl2rgb_pkg::q16_t   clamp_c [hsl2rgb_pkg::NUM_CH];

	always_comb begin
		for (int c = 0; c < hsl2rgb_pkg::NUM_CH; c++) begin
			sq_c[c]  = neg_s6[c] ? -signed'({1'b0, quo_s6[c]}) : signed'({1'b0, quo_s6[c]});
			sum_c[c] = 24'(lo_s6) + 24'(sq_c[c]);
			if (sum_c[c] < 0) begin
				clamp_c[c] = '0;
			end else if (sum_c[c] > signed'(24'(hsl2rgb_pkg::ONE_Q16))) begin
				clamp_c[c] = hsl2rgb_pkg::ONE_Q16;
			end else begin
				clamp_c[c] = sum_c[c][16:0];
			end
		end
	end

	hsl2rgb_pkg::q16_t red_s7, green_s7, blue_s7;

	always_ff @(posedge clk) begin
		if (load7) begin
			red_s7   <= clamp_c[hsl2rgb_pkg::CH_RED];
			green_s7 <= clamp_c[hsl2rgb_pkg::CH_GREEN];
			blue_s7  <= clamp_c[hsl2rgb_pkg::CH_BLUE];
		end
	end

	assign rgb.valid     = vld_s7;
	assign rgb.red_out   = red_s7;
	assign rgb.green_out = green_s7;
	assign rgb.blue_out  = blue_s7;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	logic pipe_full, rem_ok, out_ok;

	assign pipe_full = vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6 && vld_s7;
	assign rem_ok    = (rem_c[hsl2rgb_pkg::CH_RED] < 25'd30) &&
		(rem_c[hsl2rgb_pkg::CH_GREEN] < 25'd30) && (rem_c[hsl2rgb_pkg::CH_BLUE] < 25'd30);
	assign out_ok    = (rgb.red_out <= hsl2rgb_pkg::ONE_Q16) &&
		(rgb.green_out <= hsl2rgb_pkg::ONE_Q16) && (rgb.blue_out <= hsl2rgb_pkg::ONE_Q16);

	// An empty front stage always takes a request
	`H2R_ASSERT_IMP(a_front_open, clk, arst_n, !vld_s1, hsl.ready)
	// Full pipe with a stalled result blocks new requests
	`H2R_ASSERT_IMP(a_full_stall, clk, arst_n, pipe_full && !rgb.ready, !hsl.ready)
	// Reciprocal estimate is never more than one low
	`H2R_ASSERT_IMP(a_recip_err, clk, arst_n, vld_s5, rem_ok)
	// Results stay inside the clamp range
	`H2R_ASSERT_IMP(a_out_range, clk, arst_n, rgb.valid, out_ok)
	// A result in stage 6 moves into an empty output stage
	`H2R_ASSERT_NXT(a_drain, clk, arst_n, vld_s6 && !vld_s7, vld_s7)

endmodule

`default_nettype wire
